@@ design/baro_altitude_rate_tracker_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the altitude rate tracker
// Concurrent checks clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BARO_ALTITUDE_RATE_TRACKER_ASSERT_SVH
`define BARO_ALTITUDE_RATE_TRACKER_ASSERT_SVH

// same-cycle implication
`define BARAT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("barat assertion failed");

// next-cycle implication
`define BARAT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("barat assertion failed");

`endif

@@ design/barat_pkg.sv @@
// ----------------------------------------------------------------------------
// barat_pkg
// Shared constants, types and the exp2 factor table.
// ----------------------------------------------------------------------------
package barat_pkg;

   localparam int CAL_SAMPLES_DEFAULT = 30;
   localparam logic [16:0] SEA_LEVEL_RESET = 17'd101325;
   localparam logic [22:0] TOP_CM = 23'd4433000;
   localparam logic [13:0] INV_EXP_Q16 = 14'd12471;
   localparam logic [22:0] OUT_MAX = 23'h7FFFFF;

   typedef enum logic [3:0] {
      CORE_IDLE,
      CORE_LOG_MUL,
      CORE_LOG_ACC,
      CORE_SCL_MUL,
      CORE_SCL_ACC,
      CORE_EXP_MUL,
      CORE_EXP_ACC,
      CORE_FIN_MUL,
      CORE_FIN_ACC,
      CORE_SAT,
      CORE_DONE
   } core_state_type;

   typedef enum logic [2:0] {
      TRK_IDLE,
      TRK_CORE,
      TRK_DIVGO,
      TRK_DIV,
      TRK_ALT,
      TRK_VEL,
      TRK_ACC,
      TRK_OUT
   } trk_state_type;

   typedef struct packed {
      logic               done;
      logic signed [23:0] raw;
   } core_result_type;

   typedef logic [31:0] exp_table_type [16];

   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bq;
      v = v_in;
      res = '0;
      bq = 64'h4000_0000_0000_0000;
      for (int j = 0; j < 32; j++) begin
         if (v >= res + bq) begin
            v = v - (res + bq);
            res = (res >> 1) + bq;
         end else begin
            res = res >> 1;
         end
         bq = bq >> 2;
      end
      return res;
   endfunction

   // entry k holds the Q30 factor 2^(2^-(k+1))
   function automatic exp_table_type build_exp_table();
      exp_table_type tbl;
      logic [63:0] c;
      c = 64'h8000_0000;
      for (int k = 0; k < 16; k++) begin
         c = isqrt64(c << 30);
         tbl[k] = c[31:0];
      end
      return tbl;
   endfunction

   localparam exp_table_type EXP_FACTOR = build_exp_table();

   function automatic logic [4:0] msb_index(input logic [20:0] x);
      logic [4:0] idx;
      idx = '0;
      for (int j = 0; j < 21; j++) begin
         if (x[j]) begin
            idx = 5'(j);
         end
      end
      return idx;
   endfunction

   // mantissa in Q30, top bit at position 30
   function automatic logic [30:0] norm_mantissa(input logic [20:0] x);
      logic [4:0] n;
      n = msb_index(x);
      return {10'b0, x} << (5'd30 - n);
   endfunction

endpackage

@@ design/barat_mul.sv @@
// ----------------------------------------------------------------------------
// barat_mul
// Shared 32x32 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module barat_mul (
   input  logic        clock,
   input  logic [31:0] mul_a,
   input  logic [31:0] mul_b,
   output logic [63:0] prod_ff
);

   logic [63:0] prod_in;

   assign prod_in = 64'(mul_a) * 64'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

@@ design/barat_core.sv @@
// ----------------------------------------------------------------------------
// barat_core
// Raw altitude sequencer: two log2 evaluations, scaling, exp2 and final
// scaling, all through one shared multiplier.
// ----------------------------------------------------------------------------
module barat_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [20:0]               pressure,
   input  logic [16:0]               sea_level,
   output barat_pkg::core_result_type result
);

   barat_pkg::core_state_type state_ff, state_in;

   logic               p_zero_ff, p_zero_in;
   logic [16:0]        p0_ff, p0_in;
   logic               sel_ff, sel_in;
   logic [3:0]         step_ff, step_in;
   logic [4:0]         n_ff, n_in;
   logic [31:0]        m_ff, m_in;
   logic [15:0]        frac_ff, frac_in;
   logic [20:0]        logp_ff, logp_in;
   logic signed [22:0] l_ff, l_in;
   logic signed [7:0]  ish_ff, ish_in;
   logic [15:0]        f16_ff, f16_in;
   logic               half_ff, half_in;
   logic [63:0]        acc_ff, acc_in;
   logic signed [23:0] raw_ff, raw_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] prod_ff;

   logic [31:0]        sq;
   logic [15:0]        frac_new;
   logic [20:0]        logv;
   logic [22:0]        lmag;
   logic [39:0]        ymag;
   logic [39:0]        yv;
   logic [39:0]        w;
   logic [7:0]         nsh;
   logic [33:0]        scaled;
   logic signed [35:0] diff;

   barat_mul u_mul (
      .clock  (clock),
      .mul_a  (mul_a),
      .mul_b  (mul_b),
      .prod_ff(prod_ff)
   );

   // power of two from the integer part of the exponent
   always_comb begin
      nsh = 8'(-ish_ff);
      if (!ish_ff[7]) begin
         if (ish_ff > 8'sd8) begin
            w = {8'b0, m_ff} << 8;
         end else begin
            w = {8'b0, m_ff} << ish_ff[3:0];
         end
      end else if (nsh >= 8'd40) begin
         w = '0;
      end else begin
         w = {8'b0, m_ff} >> nsh[5:0];
      end
   end

   assign lmag = l_ff[22] ? 23'(-l_ff) : 23'(l_ff);

   always_comb begin
      unique case (state_ff)
         barat_pkg::CORE_SCL_MUL: begin
            mul_a = {9'b0, lmag};
            mul_b = {18'b0, barat_pkg::INV_EXP_Q16};
         end
         barat_pkg::CORE_EXP_MUL: begin
            mul_a = m_ff;
            mul_b = barat_pkg::EXP_FACTOR[step_ff];
         end
         barat_pkg::CORE_FIN_MUL: begin
            mul_a = half_ff ? {12'b0, w[39:20]} : {12'b0, w[19:0]};
            mul_b = {9'b0, barat_pkg::TOP_CM};
         end
         default: begin
            mul_a = m_ff;
            mul_b = m_ff;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      p_zero_in = p_zero_ff;
      p0_in = p0_ff;
      sel_in = sel_ff;
      step_in = step_ff;
      n_in = n_ff;
      m_in = m_ff;
      frac_in = frac_ff;
      logp_in = logp_ff;
      l_in = l_ff;
      ish_in = ish_ff;
      f16_in = f16_ff;
      half_in = half_ff;
      acc_in = acc_ff;
      raw_in = raw_ff;

      sq = prod_ff[61:30];
      frac_new = frac_ff;
      frac_new[4'd15 - step_ff] = sq[31];
      logv = {n_ff, frac_new};
      ymag = prod_ff[39:0];
      yv = l_ff[22] ? -ymag : ymag;
      scaled = acc_ff[63:30];
      diff = $signed({13'b0, barat_pkg::TOP_CM}) - $signed({2'b0, scaled});

      unique case (state_ff)
         barat_pkg::CORE_IDLE: begin
            if (start) begin
               p_zero_in = (pressure == '0);
               p0_in = (sea_level == '0) ? 17'd1 : sea_level;
               n_in = barat_pkg::msb_index(pressure);
               m_in = {1'b0, barat_pkg::norm_mantissa(pressure)};
               frac_in = '0;
               step_in = '0;
               sel_in = 1'b0;
               state_in = barat_pkg::CORE_LOG_MUL;
            end
         end
         barat_pkg::CORE_LOG_MUL: begin
            state_in = barat_pkg::CORE_LOG_ACC;
         end
         barat_pkg::CORE_LOG_ACC: begin
            m_in = sq[31] ? {1'b0, sq[31:1]} : {1'b0, sq[30:0]};
            frac_in = frac_new;
            step_in = step_ff + 4'd1;
            state_in = barat_pkg::CORE_LOG_MUL;
            if (step_ff == 4'd15) begin
               if (!sel_ff) begin
                  logp_in = logv;
                  sel_in = 1'b1;
                  n_in = barat_pkg::msb_index({4'b0, p0_ff});
                  m_in = {1'b0, barat_pkg::norm_mantissa({4'b0, p0_ff})};
                  frac_in = '0;
               end else begin
                  l_in = $signed({2'b0, logp_ff}) - $signed({2'b0, logv})
                         - 23'sd262144;
                  state_in = barat_pkg::CORE_SCL_MUL;
               end
            end
         end
         barat_pkg::CORE_SCL_MUL: begin
            state_in = barat_pkg::CORE_SCL_ACC;
         end
         barat_pkg::CORE_SCL_ACC: begin
            ish_in = $signed(yv[39:32]);
            f16_in = yv[31:16];
            m_in = 32'h4000_0000;
            step_in = '0;
            state_in = barat_pkg::CORE_EXP_MUL;
         end
         barat_pkg::CORE_EXP_MUL: begin
            state_in = barat_pkg::CORE_EXP_ACC;
         end
         barat_pkg::CORE_EXP_ACC: begin
            if (f16_ff[4'd15 - step_ff]) begin
               m_in = prod_ff[61:30];
            end
            step_in = step_ff + 4'd1;
            state_in = barat_pkg::CORE_EXP_MUL;
            if (step_ff == 4'd15) begin
               half_in = 1'b0;
               state_in = barat_pkg::CORE_FIN_MUL;
            end
         end
         barat_pkg::CORE_FIN_MUL: begin
            state_in = barat_pkg::CORE_FIN_ACC;
         end
         barat_pkg::CORE_FIN_ACC: begin
            if (!half_ff) begin
               acc_in = prod_ff + (64'd1 << 29);
               half_in = 1'b1;
               state_in = barat_pkg::CORE_FIN_MUL;
            end else begin
               acc_in = acc_ff + (prod_ff << 20);
               state_in = barat_pkg::CORE_SAT;
            end
         end
         barat_pkg::CORE_SAT: begin
            if (p_zero_ff) begin
               raw_in = $signed({1'b0, barat_pkg::TOP_CM});
            end else if (diff < -36'sd8388608) begin
               raw_in = -24'sd8388608;
            end else begin
               raw_in = diff[23:0];
            end
            state_in = barat_pkg::CORE_DONE;
         end
         barat_pkg::CORE_DONE: begin
            state_in = barat_pkg::CORE_IDLE;
         end
         default: begin
            state_in = barat_pkg::CORE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= barat_pkg::CORE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      p_zero_ff <= p_zero_in;
      p0_ff <= p0_in;
      sel_ff <= sel_in;
      step_ff <= step_in;
      n_ff <= n_in;
      m_ff <= m_in;
      frac_ff <= frac_in;
      logp_ff <= logp_in;
      l_ff <= l_in;
      ish_ff <= ish_in;
      f16_ff <= f16_in;
      half_ff <= half_in;
      acc_ff <= acc_in;
      raw_ff <= raw_in;
   end

   assign result.done = (state_ff == barat_pkg::CORE_DONE);
   assign result.raw = raw_ff;

endmodule

@@ design/barat_div.sv @@
// ----------------------------------------------------------------------------
// barat_div
// Divide by the calibration sample count through a reciprocal multiply,
// two product halves in turn on one 32x17 multiplier.
// ----------------------------------------------------------------------------
module barat_div #(
   parameter int CAL_SAMPLES = barat_pkg::CAL_SAMPLES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   output logic        done,
   output logic [31:0] quotient
);

   // ceil(2^(32+l)/d) with l = ceil(log2 d) is exact for any 32-bit dividend
   localparam int RECIP_SHIFT = $clog2(CAL_SAMPLES) + 32;
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << RECIP_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
   localparam logic [15:0] RECIP_LO = RECIP_FULL[15:0];
   localparam logic [16:0] RECIP_HI = RECIP_FULL[32:16];

   logic        busy_ff, busy_in;
   logic        hi_ff, hi_in;
   logic        done_ff, done_in;
   logic [31:0] a_ff, a_in;
   logic [47:0] lo_ff, lo_in;
   logic [31:0] quo_ff, quo_in;
   logic [16:0] mul_b;
   logic [48:0] prod;
   logic [65:0] full;

   always_comb begin
      busy_in = busy_ff;
      hi_in = hi_ff;
      done_in = 1'b0;
      a_in = a_ff;
      lo_in = lo_ff;
      quo_in = quo_ff;
      mul_b = hi_ff ? RECIP_HI : {1'b0, RECIP_LO};
      prod = {17'b0, a_ff} * {32'b0, mul_b};
      full = ({17'b0, prod} << 16) + {18'b0, lo_ff};
      if (start) begin
         busy_in = 1'b1;
         hi_in = 1'b0;
         a_in = dividend;
      end else if (busy_ff) begin
         if (!hi_ff) begin
            lo_in = prod[47:0];
            hi_in = 1'b1;
         end else begin
            quo_in = 32'(full >> RECIP_SHIFT);
            busy_in = 1'b0;
            hi_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         hi_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         hi_ff <= hi_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      lo_ff <= lo_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

@@ design/baro_altitude_rate_tracker.sv @@
// ----------------------------------------------------------------------------
// baro_altitude_rate_tracker
// Pressure samples in, altitude above base, climb rate and climb
// acceleration out. One sample is worked at a time: req_stall stays high
// from acceptance until the result word is handed to the output register,
// while the sample runs through 32 log2 squaring steps and 16 exp2 steps
// on the single shared 32x32 multiplier, plus scaling and the altitude,
// rate and acceleration steps; longer while a waiting word is stalled.
// The first CAL_SAMPLES samples give no word; the last of them adds the
// reciprocal multiply that forms the base altitude. A result word may
// wait in the output register while the next sample is worked.
// ----------------------------------------------------------------------------
module baro_altitude_rate_tracker #(
   parameter int CAL_SAMPLES = barat_pkg::CAL_SAMPLES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [20:0]        req_pressure_sample,
   input  logic signed [14:0] req_temperature_sample,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [22:0]        rsp_altitude_cm,
   output logic [22:0]        rsp_climb_rate_cm,
   output logic [22:0]        rsp_climb_accel_cm,
   output logic signed [14:0] rsp_temperature_out,
   input  logic               csr_write_enable,
   input  logic [16:0]        csr_write_data
);

   barat_pkg::trk_state_type state_ff, state_in;

   logic [16:0]        sea_level_ff, sea_level_in;
   logic               calibrated_ff, calibrated_in;
   logic [7:0]         cal_count_ff, cal_count_in;
   logic [31:0]        cal_sum_ff, cal_sum_in;
   logic signed [23:0] base_ff, base_in;
   logic [22:0]        prev_alt_ff, prev_alt_in;
   logic [22:0]        prev_vel_ff, prev_vel_in;
   logic [22:0]        held_acc_ff, held_acc_in;
   logic signed [14:0] temp_ff, temp_in;
   logic [22:0]        alt_ff, alt_in;
   logic signed [23:0] vel_ff, vel_in;
   logic [22:0]        acc_ff, acc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [22:0]        rsp_alt_ff, rsp_alt_in;
   logic [22:0]        rsp_vel_ff, rsp_vel_in;
   logic [22:0]        rsp_acc_ff, rsp_acc_in;
   logic signed [14:0] rsp_temp_ff, rsp_temp_in;

   logic                       accept;
   logic                       div_start;
   logic                       div_done;
   logic [31:0]                div_quotient;
   logic [31:0]                sum_mag;
   logic [31:0]                quo_signed;
   logic [7:0]                 cnt_next;
   logic signed [24:0]         alt_diff;
   logic signed [24:0]         acc_raw;
   logic [22:0]                vel_clamp;
   barat_pkg::core_result_type core_res;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != barat_pkg::TRK_IDLE);

   barat_core u_core (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .pressure (req_pressure_sample),
      .sea_level(sea_level_ff),
      .result   (core_res)
   );

   assign sum_mag = cal_sum_ff[31] ? -cal_sum_ff : cal_sum_ff;
   assign div_start = (state_ff == barat_pkg::TRK_DIVGO);

   barat_div #(
      .CAL_SAMPLES(CAL_SAMPLES)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(sum_mag),
      .done    (div_done),
      .quotient(div_quotient)
   );

   always_comb begin
      state_in = state_ff;
      sea_level_in = csr_write_enable ? csr_write_data : sea_level_ff;
      calibrated_in = calibrated_ff;
      cal_count_in = cal_count_ff;
      cal_sum_in = cal_sum_ff;
      base_in = base_ff;
      prev_alt_in = prev_alt_ff;
      prev_vel_in = prev_vel_ff;
      held_acc_in = held_acc_ff;
      temp_in = temp_ff;
      alt_in = alt_ff;
      vel_in = vel_ff;
      acc_in = acc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_alt_in = rsp_alt_ff;
      rsp_vel_in = rsp_vel_ff;
      rsp_acc_in = rsp_acc_ff;
      rsp_temp_in = rsp_temp_ff;

      cnt_next = cal_count_ff + 8'd1;
      quo_signed = cal_sum_ff[31] ? -div_quotient : div_quotient;
      alt_diff = $signed({core_res.raw[23], core_res.raw}) - $signed({base_ff[23], base_ff});
      acc_raw = (prev_vel_ff != '0) ?
                $signed({vel_ff[23], vel_ff}) - $signed({2'b0, prev_vel_ff}) :
                $signed({2'b0, held_acc_ff});
      vel_clamp = vel_ff[23] ? 23'd0 : vel_ff[22:0];

      unique case (state_ff)
         barat_pkg::TRK_IDLE: begin
            if (accept) begin
               temp_in = req_temperature_sample;
               state_in = barat_pkg::TRK_CORE;
            end
         end
         barat_pkg::TRK_CORE: begin
            if (core_res.done) begin
               if (!calibrated_ff) begin
                  cal_sum_in = cal_sum_ff + 32'(core_res.raw);
                  cal_count_in = cnt_next;
                  state_in = (cnt_next >= 8'(CAL_SAMPLES)) ?
                             barat_pkg::TRK_DIVGO : barat_pkg::TRK_IDLE;
               end else begin
                  state_in = barat_pkg::TRK_ALT;
               end
            end
         end
         barat_pkg::TRK_DIVGO: begin
            state_in = barat_pkg::TRK_DIV;
         end
         barat_pkg::TRK_DIV: begin
            if (div_done) begin
               base_in = quo_signed[23:0];
               calibrated_in = 1'b1;
               state_in = barat_pkg::TRK_IDLE;
            end
         end
         barat_pkg::TRK_ALT: begin
            if (alt_diff < 25'sd0) begin
               alt_in = '0;
            end else if (alt_diff > $signed({2'b0, barat_pkg::OUT_MAX})) begin
               alt_in = barat_pkg::OUT_MAX;
            end else begin
               alt_in = alt_diff[22:0];
            end
            state_in = barat_pkg::TRK_VEL;
         end
         barat_pkg::TRK_VEL: begin
            vel_in = (prev_alt_ff != '0) ?
                     $signed({1'b0, alt_ff}) - $signed({1'b0, prev_alt_ff}) :
                     $signed({1'b0, prev_vel_ff});
            state_in = barat_pkg::TRK_ACC;
         end
         barat_pkg::TRK_ACC: begin
            if (acc_raw < 25'sd0) begin
               acc_in = '0;
            end else if (acc_raw > $signed({2'b0, barat_pkg::OUT_MAX})) begin
               acc_in = barat_pkg::OUT_MAX;
            end else begin
               acc_in = acc_raw[22:0];
            end
            state_in = barat_pkg::TRK_OUT;
         end
         barat_pkg::TRK_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_alt_in = alt_ff;
               rsp_vel_in = vel_clamp;
               rsp_acc_in = acc_ff;
               rsp_temp_in = temp_ff;
               prev_alt_in = alt_ff;
               prev_vel_in = vel_clamp;
               held_acc_in = acc_ff;
               state_in = barat_pkg::TRK_IDLE;
            end
         end
         default: begin
            state_in = barat_pkg::TRK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= barat_pkg::TRK_IDLE;
         sea_level_ff <= barat_pkg::SEA_LEVEL_RESET;
         calibrated_ff <= 1'b0;
         cal_count_ff <= '0;
         cal_sum_ff <= '0;
         base_ff <= '0;
         prev_alt_ff <= '0;
         prev_vel_ff <= '0;
         held_acc_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sea_level_ff <= sea_level_in;
         calibrated_ff <= calibrated_in;
         cal_count_ff <= cal_count_in;
         cal_sum_ff <= cal_sum_in;
         base_ff <= base_in;
         prev_alt_ff <= prev_alt_in;
         prev_vel_ff <= prev_vel_in;
         held_acc_ff <= held_acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      temp_ff <= temp_in;
      alt_ff <= alt_in;
      vel_ff <= vel_in;
      acc_ff <= acc_in;
      rsp_alt_ff <= rsp_alt_in;
      rsp_vel_ff <= rsp_vel_in;
      rsp_acc_ff <= rsp_acc_in;
      rsp_temp_ff <= rsp_temp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_altitude_cm = rsp_alt_ff;
   assign rsp_climb_rate_cm = rsp_vel_ff;
   assign rsp_climb_accel_cm = rsp_acc_ff;
   assign rsp_temperature_out = rsp_temp_ff;

`include "baro_altitude_rate_tracker_assert.svh"

   `BARAT_ASSERT_NOW(a_core_done_in_wait, core_res.done, state_ff == barat_pkg::TRK_CORE)
   `BARAT_ASSERT_NEXT(a_calibrated_sticks, calibrated_ff, calibrated_ff)
   `BARAT_ASSERT_NEXT(a_accept_starts_core, accept, state_ff == barat_pkg::TRK_CORE)
   `BARAT_ASSERT_NOW(a_cal_count_bound, !calibrated_ff, cal_count_ff <= 8'(CAL_SAMPLES))

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Altitude rate tracker testbench
// Drives pressure/temperature words with random gaps and output stalls.
// A scoreboard predicts altitude, climb rate and climb acceleration.
// The predictor uses the same fixed-point log2/exp2 scheme as the block.
// The sea level pressure register is swept across several settings.
// Each result word is checked field by field.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAL_COUNT = 30;
   localparam int SETTLE_CYCLES = 200;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam longint TOP_ALT = 4433000;
   localparam longint ALT_MAX = 8388607;

   typedef struct {
      logic [22:0]        altitude;
      logic [22:0]        rate;
      logic [22:0]        accel;
      logic signed [14:0] temp;
   } alt_word_type;

   class altitude_scoreboard;
      longint unsigned exp_factor [16];
      logic [16:0] sea_level;
      bit          calibrated;
      int          cal_count;
      longint      cal_sum;
      longint      base_alt;
      longint      last_alt;
      longint      last_rate;
      longint      last_accel;
      alt_word_type expected_words [$];

      function new();
         longint unsigned c;
         c = 64'h8000_0000;
         for (int k = 0; k < 16; k++) begin
            c = int_sqrt(c << 30);
            exp_factor[k] = c;
         end
         sea_level = 17'd101325;
         calibrated = 0;
         cal_count = 0;
         cal_sum = 0;
         base_alt = 0;
         last_alt = 0;
         last_rate = 0;
         last_accel = 0;
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned res;
         longint unsigned b;
         res = 0;
         b = 64'h4000_0000_0000_0000;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= res + b) begin
               v = v - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
         return res;
      endfunction

      function longint log2_fixed(longint unsigned x);
         int n;
         longint unsigned m;
         longint frac;
         n = 0;
         frac = 0;
         while (n < 31 && (x >> (n + 1)) != 0) n++;
         m = x << (30 - n);
         for (int k = 1; k <= 16; k++) begin
            m = (m * m) >> 30;
            if (m >= 64'h8000_0000) begin
               m = m >> 1;
               frac = frac | (longint'(1) << (16 - k));
            end
         end
         return (longint'(n) << 16) + frac;
      endfunction

      function longint raw_altitude(logic [20:0] p);
         longint l, y, scaled;
         longint unsigned yo, m, w, p0;
         logic [15:0] f16;
         int i;
         if (p == 0) return TOP_ALT;
         p0 = (sea_level == 0) ? 1 : sea_level;
         l = log2_fixed(p) - log2_fixed(p0) - (longint'(4) << 16);
         y = l * 12471;
         yo = y + (longint'(64) << 32);
         i = int'(yo >> 32) - 64;
         f16 = yo[31:16];
         m = 64'h4000_0000;
         for (int k = 1; k <= 16; k++) begin
            if (f16[16 - k]) m = (m * exp_factor[k - 1]) >> 30;
         end
         if (i >= 0) w = (i > 8) ? (m << 8) : (m << i);
         else w = (-i >= 40) ? 0 : (m >> (-i));
         scaled = longint'((longint'(TOP_ALT) * w + (64'd1 << 29)) >> 30);
         scaled = TOP_ALT - scaled;
         if (scaled > ALT_MAX) scaled = ALT_MAX;
         if (scaled < -ALT_MAX - 1) scaled = -ALT_MAX - 1;
         return scaled;
      endfunction

      function void note_sample(logic [20:0] p, logic signed [14:0] t);
         longint raw, a, v, acc;
         alt_word_type wd;
         raw = raw_altitude(p);
         if (!calibrated) begin
            cal_sum += raw;
            cal_count = (cal_count + 1) & 8'hFF;
            if (cal_count >= CAL_COUNT) begin
               base_alt = cal_sum / CAL_COUNT;
               calibrated = 1;
            end
            return;
         end
         a = raw - base_alt;
         if (a < 0) a = 0;
         if (a > ALT_MAX) a = ALT_MAX;
         v = (last_alt != 0) ? a - last_alt : last_rate;
         acc = (last_rate != 0) ? v - last_rate : last_accel;
         if (v < 0) v = 0;
         if (acc < 0) acc = 0;
         if (acc > ALT_MAX) acc = ALT_MAX;
         last_alt = a;
         last_rate = v;
         last_accel = acc;
         wd.altitude = a[22:0];
         wd.rate = v[22:0];
         wd.accel = acc[22:0];
         wd.temp = t;
         expected_words.push_back(wd);
      endfunction

      function bit check_word(alt_word_type got, output string msg);
         alt_word_type e;
         if (expected_words.size() == 0) begin
            msg = "result word with nothing expected";
            return 0;
         end
         e = expected_words.pop_front();
         if (got.altitude !== e.altitude || got.rate !== e.rate ||
             got.accel !== e.accel || got.temp !== e.temp) begin
            msg = $sformatf("word mismatch: alt %0d/%0d rate %0d/%0d acc %0d/%0d temp %0d/%0d",
                            got.altitude, e.altitude, got.rate, e.rate,
                            got.accel, e.accel, got.temp, e.temp);
            return 0;
         end
         return 1;
      endfunction

      function int waiting();
         return expected_words.size();
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [20:0]        req_pressure_sample;
   logic signed [14:0] req_temperature_sample;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [22:0]        rsp_altitude_cm;
   logic [22:0]        rsp_climb_rate_cm;
   logic [22:0]        rsp_climb_accel_cm;
   logic signed [14:0] rsp_temperature_out;
   logic               csr_write_enable;
   logic [16:0]        csr_write_data;

   altitude_scoreboard sb;
   int  mismatches;
   int  idle_cycles;
   int  stall_left;
   bit  gaps_on;

   baro_altitude_rate_tracker dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_pressure_sample    (req_pressure_sample),
      .req_temperature_sample (req_temperature_sample),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_altitude_cm        (rsp_altitude_cm),
      .rsp_climb_rate_cm      (rsp_climb_rate_cm),
      .rsp_climb_accel_cm     (rsp_climb_accel_cm),
      .rsp_temperature_out    (rsp_temperature_out),
      .csr_write_enable       (csr_write_enable),
      .csr_write_data         (csr_write_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   task automatic report(string msg);
      mismatches++;
      $display("%0t: %s", $realtime, msg);
   endtask

   task automatic send_sample(logic [20:0] p, logic signed [14:0] t);
      int gap;
      gap = gaps_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_pressure_sample <= p;
      req_temperature_sample <= t;
      do @(posedge clock); while (req_stall);
      sb.note_sample(p, t);
   endtask

   task automatic write_sea_level(logic [16:0] v);
      req_valid <= 0;
      while (sb.waiting() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 0;
      sb.sea_level = v;
      @(posedge clock);
   endtask

   function automatic logic signed [14:0] rand_temp();
      return 15'($signed($urandom_range(0, 12500)) - 4000);
   endfunction

   task automatic random_phase(int count);
      int left;
      int run;
      int p;
      left = count;
      while (left > 0) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) < 7) begin
            // climb or sink run around the reference pressure
            p = int'(sb.sea_level) * 16 - $urandom_range(0, 400000);
            run = $urandom_range(3, 20);
            for (int k = 0; k < run && left > 0; k++) begin
               if ($urandom_range(0, 5) == 0) p = p + $urandom_range(0, 3000);
               else p = p - $urandom_range(0, 6000);
               if (p < 0) p = $urandom_range(0, 100);
               if (p > 2097151) p = 2097151;
               send_sample(21'(p), rand_temp());
               left--;
            end
         end else begin
            send_sample(21'($urandom_range(0, 2097151)), rand_temp());
            left--;
         end
      end
   endtask

   always @(posedge clock) begin
      alt_word_type got;
      string msg;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.altitude = rsp_altitude_cm;
         got.rate = rsp_climb_rate_cm;
         got.accel = rsp_climb_accel_cm;
         got.temp = rsp_temperature_out;
         if (!sb.check_word(got, msg)) report(msg);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         stall_left = 0;
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) stall_left = gaps_on ? $urandom_range(0, 4) : 0;
         if (stall_left > 0) begin
            rsp_stall <= 1;
            stall_left--;
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("baro_altitude_rate_tracker test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [16:0] levels [5];
      sb = new();
      mismatches = 0;
      gaps_on = 1;
      reset <= 1;
      req_valid <= 0;
      req_pressure_sample <= '0;
      req_temperature_sample <= '0;
      csr_write_enable <= 0;
      csr_write_data <= '0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // calibration words near sea level
      for (int k = 0; k < CAL_COUNT; k++)
         send_sample(21'(101325 * 16 - $urandom_range(0, 2000)), rand_temp());
      send_sample(21'd0, 15'sd8500);
      send_sample(21'd2097151, -15'sd4000);
      send_sample(21'd1700000, 15'sd0);
      send_sample(21'd1, -15'sd1);
      for (int k = 0; k < 8; k++)
         send_sample(21'(1600000 - k * k * 3000), 15'(k * 100));
      send_sample(21'd1620000, 15'sd2500);
      send_sample(21'd1621000, 15'sd2500);

      levels[0] = 17'd131071;
      levels[1] = 17'd30000;
      levels[2] = 17'd0;
      levels[3] = 17'd101325;
      levels[4] = 17'($urandom_range(30000, 131071));
      for (int ph = 0; ph < 5; ph++) begin
         write_sea_level(levels[ph]);
         random_phase(235);
      end
      req_valid <= 0;

      while (sb.waiting() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && sb.waiting() == 0) begin
         $display("baro_altitude_rate_tracker test passed");
      end else begin
         $display("baro_altitude_rate_tracker test failed");
      end
      $finish;
   end

endmodule
